// ----- rtl/ssmm_pkg.sv -----
package ssmm_pkg;

  localparam int MAX_SAMPLES_DEF = 256;
  localparam int SAMPLE_W        = 32;
  localparam int COUNT_OUT_W     = 9;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last_sample;
  } ssmm_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]    minimum;
    logic [SAMPLE_W-1:0]    maximum;
    logic [SAMPLE_W-1:0]    median;
    logic [SAMPLE_W-1:0]    mean;
    logic [COUNT_OUT_W-1:0] sample_count;
    logic                   overflow;
  } ssmm_result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_CMP,
    ST_RD_MIN,
    ST_RD_MAX,
    ST_RD_HI,
    ST_RD_LO,
    ST_DIV,
    ST_WAIT,
    ST_EMIT
  } ssmm_state_t;

  typedef enum logic [2:0] {
    RD_POSM1,
    RD_ZERO,
    RD_LAST,
    RD_HALF,
    RD_HALFM1
  } ssmm_rd_sel_t;

  typedef struct packed {
    logic         load;
    logic         wr_shift;
    logic         wr_ins;
    logic         pos_dec;
    ssmm_rd_sel_t rd_sel;
    logic         cap_min;
    logic         cap_max;
    logic         cap_hi;
    logic         cap_lo;
    logic         div_start;
    logic         emit;
  } ssmm_cmd_t;

  typedef struct packed {
    logic full;
    logic last;
    logic pos_zero;
    logic gt;
    logic div_done;
  } ssmm_status_t;

endpackage

// ----- rtl/ssmm_div.sv -----
module ssmm_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] q;
  logic [CNT_W-1:0] cnt;
  logic             run;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_next;

  // One restoring step per cycle, quotient bits shift in from the bottom.
  always_comb begin
    trial    = {rem, q[NUM_W-1]};
    diff     = trial - {1'b0, den};
    ge       = (trial >= {1'b0, den});
    rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(NUM_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
    end else if (run) begin
      q   <= {q[NUM_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quo = q;

endmodule

// ----- rtl/ssmm_ctrl.sv -----
module ssmm_ctrl
  import ssmm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  ssmm_status_t status,
  output logic         busy,
  output ssmm_cmd_t    cmd
);

  ssmm_state_t state;
  ssmm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_POSM1;
    busy       = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CHK;
        end
      end
      ST_CHK: begin
        if (status.full) begin
          state_next = status.last ? ST_RD_MIN : ST_IDLE;
        end else if (status.pos_zero) begin
          cmd.wr_ins = 1'b1;
          state_next = status.last ? ST_RD_MIN : ST_IDLE;
        end else begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        // move the larger entry up one slot, or drop the new word in place
        if (status.gt) begin
          cmd.wr_shift = 1'b1;
          cmd.pos_dec  = 1'b1;
          state_next   = ST_CHK;
        end else begin
          cmd.wr_ins = 1'b1;
          state_next = status.last ? ST_RD_MIN : ST_IDLE;
        end
      end
      ST_RD_MIN: begin
        cmd.rd_sel = RD_ZERO;
        state_next = ST_RD_MAX;
      end
      ST_RD_MAX: begin
        cmd.cap_min = 1'b1;
        cmd.rd_sel  = RD_LAST;
        state_next  = ST_RD_HI;
      end
      ST_RD_HI: begin
        cmd.cap_max = 1'b1;
        cmd.rd_sel  = RD_HALF;
        state_next  = ST_RD_LO;
      end
      ST_RD_LO: begin
        cmd.cap_hi = 1'b1;
        cmd.rd_sel = RD_HALFM1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.cap_lo    = 1'b1;
        cmd.div_start = 1'b1;
        state_next    = ST_WAIT;
      end
      ST_WAIT: begin
        if (status.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/ssmm_dp.sv -----
module ssmm_dp
  import ssmm_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  ssmm_item_t   item,
  input  ssmm_cmd_t    cmd,
  output ssmm_status_t status,
  output ssmm_result_t result,
  output logic         done
);

  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int CW    = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SAMPLE_W + AW;

  logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];
  logic [SAMPLE_W-1:0] rd_data;
  logic [AW-1:0]       raddr;

  logic [SAMPLE_W-1:0] v;
  logic                last;
  logic [AW-1:0]       pos;
  logic [CW-1:0]       count;
  logic [SUM_W-1:0]    sum;
  logic                dropped;

  logic [SAMPLE_W-1:0] min_r;
  logic [SAMPLE_W-1:0] max_r;
  logic [SAMPLE_W-1:0] hi_r;
  logic [SAMPLE_W-1:0] lo_r;
  logic [SAMPLE_W:0]   mid_sum;
  logic [SUM_W-1:0]    quo;
  logic                div_done;

  always_comb begin
    case (cmd.rd_sel)
      RD_POSM1:  raddr = pos - 1'b1;
      RD_ZERO:   raddr = '0;
      RD_LAST:   raddr = AW'(count - 1'b1);
      RD_HALF:   raddr = AW'(count >> 1);
      RD_HALFM1: raddr = AW'((count >> 1) - 1'b1);
      default:   raddr = '0;
    endcase
  end

  // Sorted store, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr_shift) begin
      mem[pos] <= rd_data;
    end else if (cmd.wr_ins) begin
      mem[pos] <= v;
    end
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      sum     <= '0;
      dropped <= 1'b0;
      pos     <= '0;
      done    <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.load) begin
        pos <= AW'(count);
        if (count == CW'(MAX_SAMPLES)) begin
          dropped <= 1'b1;
        end
      end
      if (cmd.pos_dec) begin
        pos <= pos - 1'b1;
      end
      if (cmd.wr_ins) begin
        count <= count + 1'b1;
        sum   <= sum + SUM_W'(v);
      end
      if (cmd.emit) begin
        count   <= '0;
        sum     <= '0;
        dropped <= 1'b0;
      end
    end
  end

  assign mid_sum = {1'b0, hi_r} + {1'b0, lo_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v    <= item.sample;
      last <= item.last_sample;
    end
    if (cmd.cap_min) min_r <= rd_data;
    if (cmd.cap_max) max_r <= rd_data;
    if (cmd.cap_hi)  hi_r  <= rd_data;
    if (cmd.cap_lo)  lo_r  <= rd_data;
    if (cmd.emit) begin
      result.minimum      <= min_r;
      result.maximum      <= max_r;
      result.median       <= count[0] ? hi_r : mid_sum[SAMPLE_W:1];
      result.mean         <= quo[SAMPLE_W-1:0];
      result.sample_count <= COUNT_OUT_W'(count);
      result.overflow     <= dropped;
    end
  end

  ssmm_div #(
    .NUM_W (SUM_W),
    .DEN_W (CW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (sum),
    .den   (count),
    .quo   (quo),
    .done  (div_done)
  );

  always_comb begin
    status.full     = (count == CW'(MAX_SAMPLES));
    status.last     = last;
    status.pos_zero = (pos == '0);
    status.gt       = (rd_data > v);
    status.div_done = div_done;
  end

endmodule

// ----- rtl/sample_set_min_max_median_mean_top.sv -----
// Set statistics over unsigned 32-bit timing samples.
//
// Input: drive item (sample, last_sample) and pulse start; the word is taken
// at a rising edge where start is high and busy is low. Each sample goes into
// a sorted store by insertion; the last_sample word closes the set.
// Output: on the closing word, one result word (minimum, maximum, median,
// truncated mean, sample_count, overflow) appears for exactly one cycle with
// done high. The receiver cannot stall; sample the result while done is high.
// Steps per word: take it, then check; each stored entry larger than the new
// sample takes a compare that moves it one slot up, then a check again; a
// smaller or equal entry ends the walk with a compare that inserts the word.
// The sorted store, walked one entry at a time, sets this pace.
// A closing word adds 4 store reads, a bit-serial divide of the sum, which is
// 32+log2(MAX_SAMPLES) bits wide, for the mean, and an emit that raises done.
// Samples arriving with the store full are dropped and raise overflow.
// Reset (rst, synchronous) empties the set; the store needs no clearing since
// only entries below the count are ever read. State clears after each result.
module sample_set_min_max_median_mean_top
  import ssmm_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  ssmm_item_t   item,
  output logic         busy,
  output logic         done,
  output ssmm_result_t result
);

  ssmm_cmd_t    cmd;
  ssmm_status_t status;

  // Sequencer: insertion walk, result reads, divide, emit.
  ssmm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // Store, running sum, count, divider and result register.
  ssmm_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result),
    .done   (done)
  );

`ifndef NO_ASSERTIONS
  // A result word only follows work that held the block busy.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding busy cycle");

  // A taken word always makes the block busy on the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("word taken but block not busy");

  // Sorted order: median and mean lie between minimum and maximum.
  a_order: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.minimum <= result.median) && (result.median <= result.maximum))
    else $error("median outside min/max");

  a_mean: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.minimum <= result.mean) && (result.mean <= result.maximum))
    else $error("mean outside min/max");
`endif

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import ssmm_pkg::*;

  // Run sizing: the random part sends about this many words; the limit is
  // several times the slowest legal run (every word shifting the whole store).
  localparam int RANDOM_WORDS = 1425;
  localparam int CYCLE_LIMIT  = 4_000_000;
  // Cycles to hold after the last result: one worst-case insertion plus the
  // closing reads, the divide and the emit.
  localparam int END_SETTLE   = 2 * MAX_SAMPLES_DEF + 64;

  typedef struct {
    ssmm_item_t   w;
    bit           typed;
    ssmm_result_t want;
  } probe_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         start = 1'b0;
  ssmm_item_t   item = '0;
  logic         busy;
  logic         done;
  ssmm_result_t result;

  // Predictor state: the current set, kept ascending, its sum and drop flag.
  logic [31:0]  kept_samples[$];
  logic [63:0]  sample_sum = '0;
  bit           set_overflowed = 1'b0;

  // Set statistics still owed by the block, oldest first.
  ssmm_result_t pending_stats[$];

  probe_row_t   probes[$];
  int           fail_count = 0;
  int           idle_pct = 0;
  int unsigned  cycle_count = 0;

  sample_set_min_max_median_mean_top DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always #5 clk = ~clk;

  // Fold one accepted word into the running set. Insert after every stored
  // value that is less than or equal to it, or drop it and flag overflow when
  // the store is full. On the closing word, compute the set statistics and
  // clear the set; return 1 only then.
  function automatic bit fold_sample(input ssmm_item_t w, output ssmm_result_t stats);
    int unsigned n;
    int unsigned pos;
    logic [32:0] mid;
    logic [63:0] avg;
    stats = '0;
    if (kept_samples.size() >= MAX_SAMPLES_DEF) begin
      set_overflowed = 1'b1;
    end else begin
      pos = kept_samples.size();
      while (pos > 0 && kept_samples[pos-1] > w.sample) pos--;
      kept_samples.insert(pos, w.sample);
      sample_sum += w.sample;
    end
    if (!w.last_sample) return 1'b0;
    n = kept_samples.size();
    // Average the two middles at 33 bits so the sum never wraps.
    mid = {1'b0, kept_samples[n/2]};
    if (n % 2 == 0) mid = (mid + kept_samples[n/2 - 1]) >> 1;
    avg = sample_sum / n;
    stats.minimum      = kept_samples[0];
    stats.maximum      = kept_samples[n-1];
    stats.median       = mid[31:0];
    stats.mean         = avg[31:0];
    stats.sample_count = n[COUNT_OUT_W-1:0];
    stats.overflow     = set_overflowed;
    kept_samples.delete();
    sample_sum     = '0;
    set_overflowed = 1'b0;
    return 1'b1;
  endfunction

  // Draw a sample: half full-range, with plenty of extremes and two narrow
  // bands so that duplicates and ties in the sort show up often.
  function automatic logic [31:0] pick_sample();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return 32'($urandom_range(15));
      4:       return 32'hFFFF_FFF0 | 32'($urandom_range(15));
      default: return $urandom();
    endcase
  endfunction

  function automatic probe_row_t word_row(input logic [31:0] s, input bit last);
    probe_row_t r;
    r.w.sample      = s;
    r.w.last_sample = last;
    r.typed         = 1'b0;
    r.want          = '0;
    return r;
  endfunction

  // Closing word with the statistics typed in; overflow is never set here.
  function automatic probe_row_t stats_row(input logic [31:0] s, input logic [31:0] mn,
                                           input logic [31:0] mx, input logic [31:0] md,
                                           input logic [31:0] mu, input int cnt);
    probe_row_t r;
    r = word_row(s, 1'b1);
    r.typed             = 1'b1;
    r.want.minimum      = mn;
    r.want.maximum      = mx;
    r.want.median       = md;
    r.want.mean         = mu;
    r.want.sample_count = cnt[COUNT_OUT_W-1:0];
    r.want.overflow     = 1'b0;
    return r;
  endfunction

  // Append one row to the directed table.
  function automatic void add_probe(input probe_row_t r);
    probes.insert(probes.size(), r);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
  endtask

  // Compare one result word against the oldest pending expectation.
  task automatic check_stats(input ssmm_result_t got);
    ssmm_result_t want;
    if (pending_stats.size() == 0) begin
      report_mismatch("unexpected result (mean shown)", got.mean, '0);
      return;
    end
    want = pending_stats.pop_front();
    if (got.minimum !== want.minimum) report_mismatch("minimum", got.minimum, want.minimum);
    if (got.maximum !== want.maximum) report_mismatch("maximum", got.maximum, want.maximum);
    if (got.median !== want.median) report_mismatch("median", got.median, want.median);
    if (got.mean !== want.mean) report_mismatch("mean", got.mean, want.mean);
    if (got.sample_count !== want.sample_count)
      report_mismatch("sample_count", 32'(got.sample_count), 32'(want.sample_count));
    if (got.overflow !== want.overflow)
      report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
  endtask

  // Offer one word. Called right after a rising edge. Hold start low for
  // idle cycles first, then keep start high until an edge sees busy low;
  // that edge takes the word. Start is left high so back-to-back words need
  // no second assignment in the same step.
  task automatic send_word(input ssmm_item_t w, input bit typed, input ssmm_result_t want);
    ssmm_result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= w;
    do @(posedge clk); while (busy);
    if (fold_sample(w, predicted))
      pending_stats.insert(pending_stats.size(), typed ? want : predicted);
  endtask

  // Drop start and hold until every pending result has arrived. Always
  // advance at least one edge so start is not assigned twice in one step.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_stats.size() != 0);
  endtask

  // Check every result word on the edge that ends its strobe cycle.
  always @(posedge clk) begin
    if (!rst && done) check_stats(result);
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    ssmm_item_t  w;
    int          set_idx;
    int          set_len;
    int          random_sent;
    int          phase;
    int          last_phase;

    // Directed table: extremes, full-precision median of two large middles,
    // truncating mean, duplicates and a descending run that shifts every entry.
    add_probe(stats_row(32'h0000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 1));
    add_probe(stats_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    add_probe(word_row(32'hFFFF_FFFF, 1'b0));
    add_probe(stats_row(32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                        32'hFFFF_FFFE, 32'hFFFF_FFFE, 2));
    add_probe(word_row(32'h0000_0000, 1'b0));
    add_probe(stats_row(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 2));
    add_probe(word_row(32'hAAAA_AAAA, 1'b0));
    add_probe(stats_row(32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 2));
    add_probe(word_row(32'd5, 1'b0));
    add_probe(word_row(32'd3, 1'b0));
    add_probe(word_row(32'd5, 1'b0));
    add_probe(word_row(32'd1, 1'b0));
    add_probe(word_row(32'd3, 1'b1));
    add_probe(word_row(32'd9, 1'b0));
    add_probe(word_row(32'd8, 1'b0));
    add_probe(word_row(32'd7, 1'b0));
    add_probe(word_row(32'd6, 1'b1));
    add_probe(word_row(32'd1, 1'b0));
    add_probe(word_row(32'd2, 1'b0));
    add_probe(stats_row(32'd3, 32'd1, 32'd3, 32'd2, 32'd2, 3));
    add_probe(word_row(32'd1, 1'b0));
    add_probe(stats_row(32'd2, 32'd1, 32'd2, 32'd1, 32'd1, 2));

    // Hold reset, then release it.
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[i]) send_word(probes[i].w, probes[i].typed, probes[i].want);
    drain();

    // Random sets. Most are short; a few fill the store: one exactly full
    // with the closing word stored, one where the closing word is dropped,
    // and one that overruns by several words. Idling runs in three phases,
    // with a full drain at each change.
    set_idx     = 0;
    random_sent = 0;
    last_phase  = 0;
    while (random_sent < RANDOM_WORDS) begin
      phase = random_sent * 3 / RANDOM_WORDS;
      if (phase != last_phase) begin
        drain();
        last_phase = phase;
      end
      idle_pct = (phase == 0) ? 6 : (phase == 1) ? 67 : 0;
      case (set_idx)
        2:       set_len = MAX_SAMPLES_DEF;
        9:       set_len = MAX_SAMPLES_DEF + 1;
        40:      set_len = MAX_SAMPLES_DEF + $urandom_range(8, 2);
        default: set_len = ($urandom_range(7) == 0) ? $urandom_range(40, 13)
                                                    : $urandom_range(12, 1);
      endcase
      for (int j = 0; j < set_len; j++) begin
        w.sample      = pick_sample();
        w.last_sample = (j == set_len - 1);
        send_word(w, 1'b0, '0);
      end
      random_sent += set_len;
      set_idx++;
    end

    drain();
    repeat (END_SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
